// ===== rtl/hkrb_pkg.sv =====
`timescale 1ns / 1ps

package hkrb_pkg;

    // Event codes carried on the mode field; the fourth code leaves the report unchanged
    typedef enum logic [1:0] {
        MODE_PRESS       = 2'd0,
        MODE_RELEASE     = 2'd1,
        MODE_RELEASE_ALL = 2'd2
    } mode_t;

    localparam int USAGE_W  = 7;
    localparam int MOD_W    = 8;
    localparam int CODE_W   = 8;
    localparam int OUT_SLOTS = 5;

    // Key code ranges
    localparam logic [CODE_W-1:0] RAW_BASE = 8'd136;
    localparam logic [CODE_W-1:0] MOD_BASE = 8'd128;

    // ROM entry fields
    localparam logic [7:0] ROM_SHIFT_FLAG = 8'h80;
    localparam logic [7:0] ROM_USAGE_MASK = 8'h7F;
    localparam logic [MOD_W-1:0] LEFT_SHIFT_BIT = 8'h02;

    typedef logic [USAGE_W-1:0] usage_t;

    // Decoded key event handed to the modifier and slot logic
    typedef struct packed {
        logic             press;
        logic             release_key;
        logic             clear_all;
        logic [MOD_W-1:0] mod_set;
        logic [MOD_W-1:0] mod_clr;
        usage_t           usage;
    } key_event_t;

    // ASCII to usage table; bit 7 asks for left shift
    localparam logic [7:0] USAGE_ROM [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2a, 8'h2b, 8'h28, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2c, 8'h9e, 8'hb4, 8'ha0,
        8'ha1, 8'ha2, 8'ha4, 8'h34, 8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'hb3, 8'h33,
        8'hb6, 8'h2e, 8'hb7, 8'hb8, 8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
        8'h97, 8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e,
        8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
    };

endpackage

// ===== rtl/hkrb_decode.sv =====
`timescale 1ns / 1ps

module hkrb_decode (
    input  logic [1:0]               mode,
    input  logic [7:0]               key_code,
    output hkrb_pkg::key_event_t     key_event
);

    logic [7:0]               rom_entry;
    logic [hkrb_pkg::MOD_W-1:0] mod_mask;
    hkrb_pkg::usage_t         usage;
    logic                     known;
    logic [7:0]               raw_usage;

    assign rom_entry = hkrb_pkg::USAGE_ROM[key_code[6:0]];
    assign raw_usage = key_code - hkrb_pkg::RAW_BASE;

    // Classify the key code into a usage and a modifier mask
    always_comb begin
        mod_mask = '0;
        usage    = '0;
        known    = 1'b1;
        if (key_code >= hkrb_pkg::RAW_BASE) begin
            usage = raw_usage[hkrb_pkg::USAGE_W-1:0];
        end else if (key_code >= hkrb_pkg::MOD_BASE) begin
            mod_mask = 8'(1) << key_code[2:0];
        end else if (rom_entry == 8'h00) begin
            known = 1'b0;
        end else begin
            usage = hkrb_pkg::USAGE_W'(rom_entry & hkrb_pkg::ROM_USAGE_MASK);
            if ((rom_entry & hkrb_pkg::ROM_SHIFT_FLAG) != 8'h00) begin
                mod_mask = hkrb_pkg::LEFT_SHIFT_BIT;
            end
        end
    end

    // Turn the mode into press, release or clear actions
    always_comb begin
        key_event = '0;
        case (mode)
            hkrb_pkg::MODE_PRESS: begin
                key_event.press   = known;
                key_event.mod_set = mod_mask;
                key_event.usage   = usage;
            end
            hkrb_pkg::MODE_RELEASE: begin
                key_event.release_key = known;
                key_event.mod_clr     = mod_mask;
                key_event.usage       = usage;
            end
            hkrb_pkg::MODE_RELEASE_ALL: begin
                key_event.clear_all = 1'b1;
                key_event.mod_clr   = '1;
            end
            default: begin
                key_event = '0;
            end
        endcase
    end

endmodule

// ===== rtl/hkrb_slots.sv =====
`timescale 1ns / 1ps

module hkrb_slots #(
    parameter int KEY_SLOTS = 5
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          update,
    input  hkrb_pkg::key_event_t                          key_event,
    output logic [KEY_SLOTS-1:0][hkrb_pkg::USAGE_W-1:0]   slots_next,
    output logic [KEY_SLOTS-1:0][hkrb_pkg::USAGE_W-1:0]   slots
);

    logic [KEY_SLOTS-1:0][hkrb_pkg::USAGE_W-1:0] slot_reg;
    logic [KEY_SLOTS-1:0]                        hit;
    logic [KEY_SLOTS-1:0]                        empty;
    logic [KEY_SLOTS-1:0]                        first_empty;
    logic                                        usage_nz;

    assign usage_nz = (key_event.usage != '0);

    // Compare the usage against every slot at once
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            hit[i]   = (slot_reg[i] == key_event.usage);
            empty[i] = (slot_reg[i] == '0);
        end
    end

    // Pick the lowest empty slot
    always_comb begin
        first_empty = '0;
        for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
            if (empty[i]) begin
                first_empty    = '0;
                first_empty[i] = 1'b1;
            end
        end
    end

    // Fill on press, drop on release, wipe on release-all
    always_comb begin
        slots_next = slot_reg;
        if (key_event.clear_all) begin
            slots_next = '0;
        end else if (key_event.press && usage_nz && (hit == '0)) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (first_empty[i]) begin
                    slots_next[i] = key_event.usage;
                end
            end
        end else if (key_event.release_key && usage_nz) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (hit[i]) begin
                    slots_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (update) begin
            slot_reg <= slots_next;
        end
    end

    assign slots = slot_reg;

endmodule

// ===== rtl/hid_keyboard_report_builder_top.sv =====
`timescale 1ns / 1ps
// Keyboard report builder: turns key events into boot-keyboard reports.
// Input channel (s_valid/s_ready): one word per key event, s_mode selects
// press, release or release-all, s_key_code carries ASCII, a modifier code
// or a raw usage offset by 136.
// Result channel (m_valid/m_ready): exactly one report word per event, the
// modifier byte and five usage slots (0 when empty).
// Path: a word accepted is held in the input register, then passes into
// the result register on m_*. Throughput: one event per cycle while m_ready
// stays high; the rate is set by the single pass through decode and slot
// compare between the input register and the result register.
// Reset (aresetn low, synchronous): modifiers and slots clear, both stages
// empty, s_ready high after reset.
// Receiver stall: the report holds on m_* while m_ready is low; one more event
// waits in the input register, then s_ready drops until the report is taken.

module hid_keyboard_report_builder_top #(
    parameter int KEY_SLOTS = 5
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_key_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_modifier_bits,
    output logic [6:0] m_slot_zero,
    output logic [6:0] m_slot_one,
    output logic [6:0] m_slot_two,
    output logic [6:0] m_slot_three,
    output logic [6:0] m_slot_four
);

    localparam int UW = hkrb_pkg::USAGE_W;

    logic                               in_valid_reg;
    logic [1:0]                         mode_reg;
    logic [7:0]                         code_reg;
    logic                               out_valid_reg;
    logic [hkrb_pkg::MOD_W-1:0]         modifier_reg;
    logic [hkrb_pkg::MOD_W-1:0]         modifier_next;
    logic [hkrb_pkg::OUT_SLOTS-1:0][UW-1:0] report_slot_reg;
    logic [hkrb_pkg::OUT_SLOTS-1:0][UW-1:0] report_slot_next;
    logic [KEY_SLOTS-1:0][UW-1:0]       slots_next;
    logic [KEY_SLOTS-1:0][UW-1:0]       slots_now;
    hkrb_pkg::key_event_t               key_event;
    logic                               advance;
    logic                               in_take;

    // Move the held event into the result register when it is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    hkrb_decode u_decode (
        .mode      (mode_reg),
        .key_code  (code_reg),
        .key_event (key_event)
    );

    hkrb_slots #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_slots (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .key_event  (key_event),
        .slots_next (slots_next),
        .slots      (slots_now)
    );

    // Apply modifier set and clear masks
    assign modifier_next = (modifier_reg | key_event.mod_set) & ~key_event.mod_clr;

    // Map kept slots onto the five report fields
    for (genvar j = 0; j < hkrb_pkg::OUT_SLOTS; j++) begin : g_report
        if (j < KEY_SLOTS) begin : g_shown
            assign report_slot_next[j] = slots_next[j];
        end else begin : g_blank
            assign report_slot_next[j] = '0;
        end
    end

    // Hold the input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (in_take) begin
            mode_reg <= s_mode;
            code_reg <= s_key_code;
        end
    end

    // Update modifier state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            modifier_reg  <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                modifier_reg  <= modifier_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            report_slot_reg <= report_slot_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_modifier_bits = modifier_reg;
    assign m_slot_zero     = report_slot_reg[0];
    assign m_slot_one      = report_slot_reg[1];
    assign m_slot_two      = report_slot_reg[2];
    assign m_slot_three    = report_slot_reg[3];
    assign m_slot_four     = report_slot_reg[4];

    // Slots kept but not reported still count as used
    logic unused_slots;
    assign unused_slots = ^slots_now;

endmodule

// ===== rtl/hkrb_checker.sv =====
`timescale 1ns / 1ps

module hkrb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_mode,
    input logic [7:0] s_key_code,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_modifier_bits,
    input logic [6:0] m_slot_zero,
    input logic [6:0] m_slot_one,
    input logic [6:0] m_slot_two,
    input logic [6:0] m_slot_three,
    input logic [6:0] m_slot_four
);

    logic [4:0][6:0] rpt;
    logic            dup;
    logic            too_high;

    assign rpt = {m_slot_four, m_slot_three, m_slot_two, m_slot_one, m_slot_zero};

    // Flag a usage shown twice or above the largest raw usage
    always_comb begin
        dup      = 1'b0;
        too_high = 1'b0;
        for (int i = 0; i < 5; i++) begin
            if (rpt[i] > 7'd119) begin
                too_high = 1'b1;
            end
            for (int k = i + 1; k < 5; k++) begin
                if (rpt[i] != '0 && rpt[i] == rpt[k]) begin
                    dup = 1'b1;
                end
            end
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result or input stage not empty after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_modifier_bits) && $stable(rpt))
        else $error("report changed while stalled");

    a_no_dup: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !dup)
        else $error("same usage in two slots");

    a_usage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !too_high)
        else $error("slot usage out of range");

    logic unused_in;
    assign unused_in = s_valid ^ (^s_mode) ^ (^s_key_code);

endmodule

bind hid_keyboard_report_builder_top hkrb_checker u_hkrb_checker (.*);

// ===== sim/tb_hid_keyboard_report_builder_top.sv =====
`timescale 1ns / 1ps

module tb_hid_keyboard_report_builder_top;

    localparam int          RANDOM_EVENTS  = 600;
    localparam int          IDLE_LIMIT     = 1000;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          TRACKED_SLOTS  = 5;
    localparam logic [1:0]  MODE_UNUSED    = 2'd3;

    // Receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKS
    } rx_style_t;

    typedef struct packed {
        logic [hkrb_pkg::MOD_W-1:0]              mods;
        hkrb_pkg::usage_t [TRACKED_SLOTS-1:0]    slots;
    } key_report_t;

    // Keeps its own modifier byte and usage slots and queues the report each event gives
    class report_tracker;
        logic [hkrb_pkg::MOD_W-1:0] held_mods;
        hkrb_pkg::usage_t           held_usages [TRACKED_SLOTS];
        logic [7:0]                 key_table [128];
        string                      slot_name [TRACKED_SLOTS];
        key_report_t                expected_reports [$];
        int                         errors;

        function new();
            held_mods = '0;
            foreach (held_usages[i]) held_usages[i] = '0;
            errors = 0;
            slot_name = '{"slot_zero", "slot_one", "slot_two", "slot_three", "slot_four"};
            key_table = '{
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2a, 8'h2b, 8'h28,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2c,
                8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34, 8'ha6, 8'ha7, 8'ha5, 8'hae,
                8'h36, 8'h2d, 8'h37, 8'h38, 8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23,
                8'h24, 8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8, 8'h9f, 8'h84,
                8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f,
                8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
                8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had, 8'h35, 8'h04, 8'h05,
                8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10,
                8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b,
                8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
            };
        endfunction

        function void note_event(logic [1:0] mode, logic [7:0] code);
            logic [7:0]       entry;
            hkrb_pkg::usage_t usage;
            logic             is_key;
            logic             found;
            logic             placed;
            key_report_t      rep;
            is_key = 1'b1;
            usage  = '0;
            if (mode == hkrb_pkg::MODE_PRESS || mode == hkrb_pkg::MODE_RELEASE) begin
                // Decode: raw usage, modifier bit, or table lookup with optional shift
                if (code >= hkrb_pkg::RAW_BASE) begin
                    usage = hkrb_pkg::usage_t'(code - hkrb_pkg::RAW_BASE);
                end else if (code >= hkrb_pkg::MOD_BASE) begin
                    held_mods[code[2:0]] = (mode == hkrb_pkg::MODE_PRESS);
                end else begin
                    entry = key_table[code[6:0]];
                    if (entry == 8'h00) begin
                        is_key = 1'b0;
                    end else begin
                        if ((entry & hkrb_pkg::ROM_SHIFT_FLAG) != 0) begin
                            if (mode == hkrb_pkg::MODE_PRESS) begin
                                held_mods = held_mods | hkrb_pkg::LEFT_SHIFT_BIT;
                            end else begin
                                held_mods = held_mods & ~hkrb_pkg::LEFT_SHIFT_BIT;
                            end
                        end
                        usage = hkrb_pkg::usage_t'(entry & hkrb_pkg::ROM_USAGE_MASK);
                    end
                end
                // Update slots: press fills the first empty slot, release clears matches
                if (is_key && usage != '0) begin
                    if (mode == hkrb_pkg::MODE_PRESS) begin
                        found  = 1'b0;
                        placed = 1'b0;
                        foreach (held_usages[i]) if (held_usages[i] == usage) found = 1'b1;
                        foreach (held_usages[i]) begin
                            if (!found && !placed && held_usages[i] == '0) begin
                                held_usages[i] = usage;
                                placed = 1'b1;
                            end
                        end
                    end else begin
                        foreach (held_usages[i]) if (held_usages[i] == usage) held_usages[i] = '0;
                    end
                end
            end else if (mode == hkrb_pkg::MODE_RELEASE_ALL) begin
                held_mods = '0;
                foreach (held_usages[i]) held_usages[i] = '0;
            end
            rep.mods = held_mods;
            foreach (held_usages[i]) rep.slots[i] = held_usages[i];
            expected_reports.push_back(rep);
        endfunction

        function void check_report(key_report_t got);
            key_report_t want;
            if (expected_reports.size() == 0) begin
                $error("report word with no event pending: modifier_bits %h", got.mods);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.mods !== want.mods) begin
                $error("modifier_bits: expected %h, got %h", want.mods, got.mods);
                errors++;
            end
            for (int i = 0; i < TRACKED_SLOTS; i++) begin
                if (got.slots[i] !== want.slots[i]) begin
                    $error("%s: expected %h, got %h", slot_name[i], want.slots[i],
                           got.slots[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode = '0;
    logic [7:0] s_key_code = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_modifier_bits;
    logic [6:0] m_slot_zero;
    logic [6:0] m_slot_one;
    logic [6:0] m_slot_two;
    logic [6:0] m_slot_three;
    logic [6:0] m_slot_four;

    report_tracker tracker;
    int            burst_left = 0;
    int            idle_cycles = 0;
    rx_style_t     rx_style = RX_OPEN;
    int            rx_left = 0;
    logic [7:0]    recent_codes [8];
    logic [2:0]    recent_idx = '0;

    hid_keyboard_report_builder_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_key_code      (s_key_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_modifier_bits (m_modifier_bits),
        .m_slot_zero     (m_slot_zero),
        .m_slot_one      (m_slot_one),
        .m_slot_two      (m_slot_two),
        .m_slot_three    (m_slot_three),
        .m_slot_four     (m_slot_four)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Pick a receiver stall style for a while, then switch
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_style <= rx_style_t'($urandom_range(0, 3));
            rx_left  <= $urandom_range(16, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= rx_left[3];
        endcase
    end

    // Sample both channels: check reports, note accepted events, watch for a hang
    always @(posedge aclk) begin : sample
        key_report_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.mods  = m_modifier_bits;
                got.slots = {m_slot_four, m_slot_three, m_slot_two, m_slot_one, m_slot_zero};
                tracker.check_report(got);
            end
            if (s_valid && s_ready) tracker.note_event(s_mode, s_key_code);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("tb_hid_keyboard_report_builder_top NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Send one key event word, with a random gap whenever a burst runs out
    task automatic send_key(input logic [1:0] mode, input logic [7:0] code);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
            if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(30, 60);
            else burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_key_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly printable keys and raw usages, some modifiers, some of anything
    function automatic logic [7:0] pick_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 8'($urandom_range(32, 126));
        else if (roll < 55) return hkrb_pkg::MOD_BASE + 8'($urandom_range(0, 7));
        else if (roll < 85) return hkrb_pkg::RAW_BASE + 8'($urandom_range(0, 119));
        else return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int         roll;
        logic [1:0] mode;
        logic [7:0] code;
        tracker = new();
        foreach (recent_codes[i]) recent_codes[i] = 8'h61 + 8'(i);
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: shifted and plain keys, duplicates, modifier extremes, raw extremes
        send_key(hkrb_pkg::MODE_PRESS, 8'h61);
        send_key(hkrb_pkg::MODE_PRESS, 8'h41);
        send_key(hkrb_pkg::MODE_PRESS, hkrb_pkg::MOD_BASE);
        send_key(hkrb_pkg::MODE_PRESS, hkrb_pkg::MOD_BASE + 8'd7);
        send_key(hkrb_pkg::MODE_PRESS, hkrb_pkg::RAW_BASE);
        send_key(hkrb_pkg::MODE_PRESS, 8'hFF);
        send_key(hkrb_pkg::MODE_PRESS, 8'h21);
        send_key(hkrb_pkg::MODE_PRESS, 8'h31);
        send_key(hkrb_pkg::MODE_PRESS, 8'h62);
        send_key(hkrb_pkg::MODE_PRESS, 8'h63);
        // All slots taken: a new key is dropped, table holes are ignored
        send_key(hkrb_pkg::MODE_PRESS, 8'h64);
        send_key(hkrb_pkg::MODE_PRESS, 8'h00);
        send_key(hkrb_pkg::MODE_PRESS, 8'h7F);
        send_key(hkrb_pkg::MODE_RELEASE, 8'h0B);
        send_key(hkrb_pkg::MODE_RELEASE, 8'h41);
        send_key(hkrb_pkg::MODE_RELEASE, hkrb_pkg::MOD_BASE + 8'd7);
        send_key(hkrb_pkg::MODE_RELEASE, hkrb_pkg::RAW_BASE);
        send_key(hkrb_pkg::MODE_RELEASE, 8'hFF);
        send_key(MODE_UNUSED, 8'hFF);
        send_key(hkrb_pkg::MODE_PRESS, 8'h64);
        send_key(hkrb_pkg::MODE_RELEASE_ALL, 8'hAA);
        send_key(MODE_UNUSED, 8'h00);
        send_key(hkrb_pkg::MODE_PRESS, 8'h0A);
        send_key(hkrb_pkg::MODE_RELEASE, 8'h7F);

        // Random typing: presses and releases of recent keys, rare clears and noise
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 48) mode = hkrb_pkg::MODE_PRESS;
            else if (roll < 88) mode = hkrb_pkg::MODE_RELEASE;
            else if (roll < 94) mode = hkrb_pkg::MODE_RELEASE_ALL;
            else mode = MODE_UNUSED;
            if (mode == hkrb_pkg::MODE_RELEASE && $urandom_range(0, 3) != 0)
                code = recent_codes[$urandom_range(0, 7)];
            else if (mode == hkrb_pkg::MODE_PRESS && $urandom_range(0, 5) == 0)
                code = recent_codes[$urandom_range(0, 7)];
            else
                code = pick_code();
            if (mode == hkrb_pkg::MODE_PRESS) begin
                recent_codes[recent_idx] = code;
                recent_idx++;
            end
            send_key(mode, code);
        end
        s_valid <= 1'b0;

        // Drain outstanding reports, then allow a few more cycles for stray words
        while (tracker.expected_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.expected_reports.size() != 0) begin
            $error("%0d reports never arrived", tracker.expected_reports.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("tb_hid_keyboard_report_builder_top OK");
        end else begin
            $display("tb_hid_keyboard_report_builder_top NOT OK");
        end
        $finish;
    end

endmodule
